### sv/assert_macros.svh
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define RZFF_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RZFF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RZFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/rzff_pkg.sv
// shared types and constants of the zone allocator
`timescale 1ns / 1ps

package rzff_pkg;

	localparam int MAX_DEVICES_DEF = 4;
	localparam int MAX_ZONES_DEF   = 256;

	localparam int QDEPTH = 2;

	localparam logic [2:0] DEVICES_RESET = 3'd4;
	localparam logic [8:0] ZONES_RESET   = 9'd256;

	localparam logic REG_DEVICES = 1'b0;
	localparam logic REG_ZONES   = 1'b1;

	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_SET    = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_SET    = 2'd1;
	localparam logic [1:0] OP_DROP   = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] lzone;
		logic [9:0] lslot;
		logic [1:0] pdev;
		logic [7:0] pzone;
	} cmd_t;

endpackage

### sv/rzff_front.sv
// command intake: classifies transactions and queues them for the engine
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rzff_front #(
	parameter int MAX_DEVICES = rzff_pkg::MAX_DEVICES_DEF,
	parameter int MAX_ZONES   = rzff_pkg::MAX_ZONES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clearing,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [7:0]        logical_zone,
	input  logic [9:0]        logical_slot,
	input  logic [1:0]        physical_device,
	input  logic [7:0]        physical_zone,
	output logic              q_valid,
	output rzff_pkg::cmd_t    q_item,
	input  logic              q_pop
);

	rzff_pkg::cmd_t entry_q [rzff_pkg::QDEPTH];
	rzff_pkg::cmd_t item;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;

	always_comb begin
		item.lzone = logical_zone;
		item.lslot = logical_slot;
		item.pdev  = physical_device;
		item.pzone = physical_zone;
		if (command == rzff_pkg::CMD_SET) begin
			if (int'(physical_device) >= MAX_DEVICES || int'(physical_zone) >= MAX_ZONES) begin
				item.op = rzff_pkg::OP_DROP;
			end else begin
				item.op = rzff_pkg::OP_SET;
			end
		end else begin
			item.op = rzff_pkg::OP_CREATE;
		end
	end

	assign in_ready = (int'(count_q) != rzff_pkg::QDEPTH) && !clearing;
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`RZFF_ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, q_pop, count_q != 2'd0, "pop from empty queue")
	`RZFF_ASSERT_ALWAYS(a_count_bound, clk, arst_n, int'(count_q) <= rzff_pkg::QDEPTH, "queue overfull")

endmodule

### sv/rzff_back.sv
// allocation engine: occupancy store, first-fit scan and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rzff_back #(
	parameter int MAX_DEVICES = rzff_pkg::MAX_DEVICES_DEF,
	parameter int MAX_ZONES   = rzff_pkg::MAX_ZONES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        devices_in_use,
	input  logic [8:0]        zones_in_use,
	input  logic              q_valid,
	input  rzff_pkg::cmd_t    q_item,
	output logic              q_pop,
	output logic              clearing,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [9:0]        mapped_slot,
	output logic [1:0]        mapped_device,
	output logic [7:0]        mapped_zone,
	output logic              slot_valid,
	output logic              last,
	output logic              status
);

	localparam int ZW  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int DIW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

	typedef logic [MAX_DEVICES-1:0] row_t;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_CR_RD  = 4'd2;
	localparam logic [3:0] ST_CR_LD  = 4'd3;
	localparam logic [3:0] ST_SCAN   = 4'd4;
	localparam logic [3:0] ST_FIN    = 4'd5;
	localparam logic [3:0] ST_SET_RD = 4'd6;
	localparam logic [3:0] ST_SET_WR = 4'd7;
	localparam logic [3:0] ST_DROP   = 4'd8;

	row_t mem_q [MAX_ZONES];
	row_t rd_q;
	row_t row_q;

	logic [3:0]     state_q;
	logic [ZW-1:0]  clr_q;
	logic [ZW-1:0]  zone_q;
	logic [2:0]     taken_q;
	logic [9:0]     base_q;
	rzff_pkg::cmd_t cmd_q;
	logic           pend_valid_q;
	logic [9:0]     pend_slot_q;
	logic [1:0]     pend_dev_q;
	logic [7:0]     pend_zone_q;
	logic           out_valid_q;
	logic [9:0]     out_slot_q;
	logic [1:0]     out_dev_q;
	logic [7:0]     out_zone_q;
	logic           out_sv_q;
	logic           out_last_q;
	logic           out_status_q;

	logic [2:0]     ndev;
	logic [8:0]     nzone;
	row_t           devmask;
	row_t           free;
	logic [DIW-1:0] found_d;
	logic           want;
	logic           take;
	logic           row_done;
	logic           finish_scan;
	logic           advance;
	logic           out_space;
	logic [ZW-1:0]  set_addr;
	row_t           set_mask;

	logic           mem_we;
	logic [ZW-1:0]  mem_waddr;
	row_t           mem_wdata;
	logic           mem_re;
	logic [ZW-1:0]  mem_raddr;

	logic           push;
	logic [9:0]     o_slot;
	logic [1:0]     o_dev;
	logic [7:0]     o_zone;
	logic           o_sv;
	logic           o_last;
	logic           o_status;

	always_comb begin
		ndev  = (int'(devices_in_use) > MAX_DEVICES) ? 3'(MAX_DEVICES) : devices_in_use;
		nzone = (int'(zones_in_use) > MAX_ZONES) ? 9'(MAX_ZONES) : zones_in_use;
		for (int d = 0; d < MAX_DEVICES; d++) begin
			devmask[d] = (d < int'(ndev));
		end
		free    = ~row_q & devmask;
		found_d = '0;
		for (int d = MAX_DEVICES - 1; d >= 0; d--) begin
			if (free[d]) begin
				found_d = DIW'(d);
			end
		end
	end

	assign want        = (taken_q < ndev);
	assign take        = (state_q == ST_SCAN) && want && (|free);
	assign row_done    = (state_q == ST_SCAN) && !(want && (|free));
	assign finish_scan = row_done && (!want || (int'(zone_q) + 1 >= int'(nzone)));
	assign advance     = row_done && !finish_scan;
	assign out_space   = !out_valid_q || out_ready;
	assign set_addr    = ZW'(cmd_q.pzone);
	assign set_mask    = row_t'(1) << cmd_q.pdev;
	assign q_pop       = (state_q == ST_IDLE) && q_valid;
	assign clearing    = (state_q == ST_CLEAR);

	// occupancy store ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = zone_q;
		mem_wdata = row_q;
		mem_re    = 1'b0;
		mem_raddr = zone_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_CR_RD: begin
				mem_re    = 1'b1;
				mem_raddr = '0;
			end
			ST_CR_LD: begin
				mem_re    = (int'(nzone) > 1);
				mem_raddr = ZW'(1);
			end
			ST_SCAN: begin
				mem_we = row_done;
				if (advance) begin
					mem_re    = (int'(zone_q) + 2 < int'(nzone));
					mem_raddr = zone_q + ZW'(2);
				end
			end
			ST_SET_RD: begin
				mem_re    = 1'b1;
				mem_raddr = set_addr;
			end
			ST_SET_WR: begin
				mem_we    = out_space;
				mem_waddr = set_addr;
				mem_wdata = rd_q | set_mask;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_raddr];
		end
	end

	// result selection
	always_comb begin
		push     = 1'b0;
		o_slot   = '0;
		o_dev    = '0;
		o_zone   = '0;
		o_sv     = 1'b0;
		o_last   = 1'b1;
		o_status = rzff_pkg::STATUS_OK;
		case (state_q)
			ST_SCAN: begin
				push   = take && out_space && pend_valid_q;
				o_slot = pend_slot_q;
				o_dev  = pend_dev_q;
				o_zone = pend_zone_q;
				o_sv   = 1'b1;
				o_last = 1'b0;
			end
			ST_FIN: begin
				push = out_space;
				if (pend_valid_q) begin
					o_slot   = pend_slot_q;
					o_dev    = pend_dev_q;
					o_zone   = pend_zone_q;
					o_sv     = 1'b1;
					o_status = want ? rzff_pkg::STATUS_NO_SPACE : rzff_pkg::STATUS_OK;
				end else begin
					o_status = (ndev != 3'd0) ? rzff_pkg::STATUS_NO_SPACE
						: rzff_pkg::STATUS_OK;
				end
			end
			ST_SET_WR: begin
				push   = out_space;
				o_slot = cmd_q.lslot;
				o_dev  = cmd_q.pdev;
				o_zone = cmd_q.pzone;
				o_sv   = 1'b1;
			end
			ST_DROP: begin
				push = out_space;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			taken_q      <= 3'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q  <= 1'b1;
				out_slot_q   <= o_slot;
				out_dev_q    <= o_dev;
				out_zone_q   <= o_zone;
				out_sv_q     <= o_sv;
				out_last_q   <= o_last;
				out_status_q <= o_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (int'(clr_q) == MAX_ZONES - 1) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + ZW'(1);
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_item;
						taken_q <= 3'd0;
						zone_q  <= '0;
						base_q  <= 10'({3'b000, q_item.lzone} * {8'd0, ndev});
						case (q_item.op)
							rzff_pkg::OP_CREATE: begin
								if (ndev == 3'd0 || nzone == 9'd0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_CR_RD;
								end
							end
							rzff_pkg::OP_SET: begin
								state_q <= ST_SET_RD;
							end
							default: begin
								state_q <= ST_DROP;
							end
						endcase
					end
				end
				ST_CR_RD: begin
					state_q <= ST_CR_LD;
				end
				ST_CR_LD: begin
					row_q   <= rd_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (take) begin
						if (out_space) begin
							pend_valid_q <= 1'b1;
							pend_slot_q  <= base_q + 10'(taken_q);
							pend_dev_q   <= 2'(found_d);
							pend_zone_q  <= 8'(zone_q);
							row_q        <= row_q | (row_t'(1) << found_d);
							taken_q      <= taken_q + 3'd1;
						end
					end else if (finish_scan) begin
						state_q <= ST_FIN;
					end else begin
						row_q  <= rd_q;
						zone_q <= zone_q + ZW'(1);
					end
				end
				ST_FIN: begin
					if (out_space) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_SET_RD: begin
					state_q <= ST_SET_WR;
				end
				ST_SET_WR, ST_DROP: begin
					if (out_space) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign mapped_slot   = out_slot_q;
	assign mapped_device = out_dev_q;
	assign mapped_zone   = out_zone_q;
	assign slot_valid    = out_sv_q;
	assign last          = out_last_q;
	assign status        = out_status_q;

	`RZFF_ASSERT_IMPLIES(a_taken_bound, clk, arst_n, state_q == ST_SCAN || state_q == ST_FIN, taken_q <= ndev, "more slots taken than devices")
	`RZFF_ASSERT_IMPLIES(a_pend_track, clk, arst_n, state_q == ST_SCAN, pend_valid_q == (taken_q != 3'd0), "pending result out of step with count")
	`RZFF_ASSERT_NEXT(a_clear_once, clk, arst_n, state_q != ST_CLEAR, state_q != ST_CLEAR, "clearing pass restarted")

endmodule

### sv/raid_zone_first_fit_allocator.sv
// top level of the first-fit raid zone slot allocator
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes devices_in_use
//   (index 0) and zones_in_use (index 1); cfg_ready is always high, write only
//   while the block is idle.
//   in channel (in_valid/in_ready) takes one command per transaction: create
//   maps a logical zone onto free (device, zone) slots first-fit, set marks one
//   slot occupied, and a set out of range is dropped. Commands pass through a
//   two-entry queue to the engine. out channel (out_valid/out_ready) gives
//   one transaction per slot taken, or one with slot_valid low if none; the
//   final one has last set and carries the status. A create loads the first
//   zone row, then scans the rows of the occupancy store through its single
//   read port, one row per cycle where no slot is taken; a set reads the
//   target row, then writes it back.
//   Reset: config returns to 4 devices and 256 zones; the whole store is then
//   wiped one row per cycle, with in_ready low meanwhile.
//   Stall: the result sits in an output register; while out_ready is low and
//   the register is full the engine holds and the queue keeps accepting until full.
`timescale 1ns / 1ps

module raid_zone_first_fit_allocator #(
	parameter int MAX_DEVICES = rzff_pkg::MAX_DEVICES_DEF,
	parameter int MAX_ZONES   = rzff_pkg::MAX_ZONES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  logical_zone,
	input  logic [9:0]  logical_slot,
	input  logic [1:0]  physical_device,
	input  logic [7:0]  physical_zone,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  mapped_slot,
	output logic [1:0]  mapped_device,
	output logic [7:0]  mapped_zone,
	output logic        slot_valid,
	output logic        last,
	output logic        status
);

	logic [2:0]     devices_in_use_q;
	logic [8:0]     zones_in_use_q;
	logic           q_valid;
	rzff_pkg::cmd_t q_item;
	logic           q_pop;
	logic           clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			devices_in_use_q <= rzff_pkg::DEVICES_RESET;
			zones_in_use_q   <= rzff_pkg::ZONES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rzff_pkg::REG_DEVICES: devices_in_use_q <= cfg_data[2:0];
				rzff_pkg::REG_ZONES:   zones_in_use_q   <= cfg_data;
				default:               zones_in_use_q   <= zones_in_use_q;
			endcase
		end
	end

	rzff_front #(
		.MAX_DEVICES (MAX_DEVICES),
		.MAX_ZONES   (MAX_ZONES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.clearing        (clearing),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.logical_zone    (logical_zone),
		.logical_slot    (logical_slot),
		.physical_device (physical_device),
		.physical_zone   (physical_zone),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	rzff_back #(
		.MAX_DEVICES (MAX_DEVICES),
		.MAX_ZONES   (MAX_ZONES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.devices_in_use (devices_in_use_q),
		.zones_in_use   (zones_in_use_q),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.mapped_slot    (mapped_slot),
		.mapped_device  (mapped_device),
		.mapped_zone    (mapped_zone),
		.slot_valid     (slot_valid),
		.last           (last),
		.status         (status)
	);

endmodule
